// ----- rtl/vau_pkg.sv -----
// Shared types, constants and trig tables of the vector angle unit.
package vau_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int ANGLE_W = 8;
    localparam int SEARCH_STEPS = 8;
    localparam int TAB_LAST = 90;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;
    localparam logic [63:0] Q62_ONE = 64'h4000000000000000;
    localparam logic [63:0] ONE_DEG = PI_Q62 / 180;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
    localparam logic [ANGLE_W-1:0] ANGLE_RIGHT = 8'd90;

    typedef logic [63:0] t_q62;
    typedef t_q62 t_trig_tab [0:TAB_LAST];

    // Search bounds and flags that travel with an item through the pipeline.
    typedef struct packed {
        logic [ANGLE_W-1:0] lo;
        logic [ANGLE_W-1:0] hi;
        logic               dneg;
        logic               opp;
        logic               perp;
        logic               inv;
    } t_ctl;

    function automatic t_q62 mul_q62(input t_q62 a, input t_q62 b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[125:62];
    endfunction

    // Taylor series of sine or cosine at m degrees, in Q2.62.
    function automatic t_q62 trig_q62(input int m, input bit want_sin);
        t_q62 x;
        t_q62 x2;
        t_q62 st;
        t_q62 ss;
        t_q62 ct;
        t_q62 cs;
        x  = 64'(m) * ONE_DEG;
        x2 = mul_q62(x, x);
        st = x;
        ss = x;
        ct = Q62_ONE;
        cs = Q62_ONE;
        for (int n = 1; n < 40; n++) begin
            st = mul_q62(st, x2) / 64'((2 * n) * (2 * n + 1));
            ct = mul_q62(ct, x2) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                ss = ss - st;
                cs = cs - ct;
            end else begin
                ss = ss + st;
                cs = cs + ct;
            end
            if (st == 0 && ct == 0) break;
        end
        return want_sin ? ss : cs;
    endfunction

    // Right angle is exact; at 45 degrees sine is taken equal to cosine.
    function automatic t_trig_tab build_tab(input bit want_sin);
        t_trig_tab t;
        for (int m = 0; m <= TAB_LAST; m++) begin
            if (m == TAB_LAST) begin
                t[m] = want_sin ? Q62_ONE : 64'd0;
            end else if (m == 45) begin
                t[m] = trig_q62(m, 1'b0);
            end else begin
                t[m] = trig_q62(m, want_sin);
            end
        end
        return t;
    endfunction

    localparam t_trig_tab COS_TAB = build_tab(1'b0);
    localparam t_trig_tab SIN_TAB = build_tab(1'b1);

endpackage

// ----- rtl/vau_front.sv -----
// Front end: products, dot and cross magnitudes, and the item flags.
module vau_front #(
    parameter int CB = vau_pkg::COMPONENT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CB-1:0] i_ax,
    input  logic signed [CB-1:0] i_ay,
    input  logic signed [CB-1:0] i_bx,
    input  logic signed [CB-1:0] i_by,
    output logic                 o_valid,
    output vau_pkg::t_ctl        o_ctl,
    output logic [2*CB-1:0]      o_cmag,
    output logic [2*CB-1:0]      o_dmag
);
    localparam int PW = 2 * CB;

    logic                 r_v1;
    logic signed [PW-1:0] r_axbx;
    logic signed [PW-1:0] r_ayby;
    logic signed [PW-1:0] r_axby;
    logic signed [PW-1:0] r_aybx;
    logic                 r_inv1;
    logic signed [PW:0]   dot;
    logic signed [PW:0]   crs;
    logic signed [PW:0]   dabs;
    logic signed [PW:0]   cabs;
    logic                 r_v2;
    vau_pkg::t_ctl        r_ctl;
    logic [PW-1:0]        r_cmag;
    logic [PW-1:0]        r_dmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_axbx <= PW'(i_ax) * PW'(i_bx);
            r_ayby <= PW'(i_ay) * PW'(i_by);
            r_axby <= PW'(i_ax) * PW'(i_by);
            r_aybx <= PW'(i_ay) * PW'(i_bx);
            r_inv1 <= (i_ax == '0 && i_ay == '0) || (i_bx == '0 && i_by == '0);
        end
    end

    always_comb begin
        dot  = (PW+1)'(r_axbx) + (PW+1)'(r_ayby);
        crs  = (PW+1)'(r_axby) - (PW+1)'(r_aybx);
        dabs = dot[PW] ? -dot : dot;
        cabs = crs[PW] ? -crs : crs;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl.lo   <= '0;
            r_ctl.hi   <= vau_pkg::ANGLE_MAX;
            r_ctl.dneg <= dot[PW];
            r_ctl.opp  <= (crs == '0) && dot[PW];
            r_ctl.perp <= (dot == '0);
            r_ctl.inv  <= r_inv1;
            r_cmag     <= cabs[PW-1:0];
            r_dmag     <= dabs[PW-1:0];
        end
    end

    assign o_valid = r_v2;
    assign o_ctl   = r_ctl;
    assign o_cmag  = r_cmag;
    assign o_dmag  = r_dmag;
endmodule

// ----- rtl/vau_search_step.sv -----
// One binary search step over the angle: a product stage and a compare stage.
module vau_search_step #(
    parameter int MAG_W = 2 * vau_pkg::COMPONENT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  vau_pkg::t_ctl    i_ctl,
    input  logic [MAG_W-1:0] i_cmag,
    input  logic [MAG_W-1:0] i_dmag,
    output logic             o_valid,
    output vau_pkg::t_ctl    o_ctl,
    output logic [MAG_W-1:0] o_cmag,
    output logic [MAG_W-1:0] o_dmag
);
    localparam int NC = (MAG_W + 31) / 32;
    localparam int NP = 2 * NC;
    localparam int SW = 64 + NC * 32;
    localparam int AW = vau_pkg::ANGLE_W;

    logic [AW:0]       mid_sum;
    logic [AW-1:0]     mid;
    logic [6:0]        m;
    vau_pkg::t_q62     cv;
    vau_pkg::t_q62     sv;
    logic [NC*32-1:0]  cpad;
    logic [NC*32-1:0]  dpad;
    logic [63:0]       n_pc [NP];
    logic [63:0]       n_ps [NP];

    logic              r_va;
    vau_pkg::t_ctl     r_ctla;
    logic [MAG_W-1:0]  r_cmaga;
    logic [MAG_W-1:0]  r_dmaga;
    logic [AW-1:0]     r_mid;
    logic [63:0]       r_pc [NP];
    logic [63:0]       r_ps [NP];

    logic [SW-1:0]     lmag;
    logic [SW-1:0]     rmag;
    logic              lneg;
    logic              rneg;
    logic              ge;
    logic              hit;
    vau_pkg::t_ctl     n_ctl;

    logic              r_vb;
    vau_pkg::t_ctl     r_ctlb;
    logic [MAG_W-1:0]  r_cmagb;
    logic [MAG_W-1:0]  r_dmagb;

    always_comb begin
        mid_sum = (AW+1)'(i_ctl.lo) + (AW+1)'(i_ctl.hi) + (AW+1)'(1);
        mid     = mid_sum[AW:1];
        if (mid >= vau_pkg::ANGLE_MAX) begin
            m = '0;
        end else if (mid > vau_pkg::ANGLE_RIGHT) begin
            m = 7'(vau_pkg::ANGLE_MAX - mid);
        end else begin
            m = 7'(mid);
        end
        cv   = vau_pkg::COS_TAB[m];
        sv   = vau_pkg::SIN_TAB[m];
        cpad = (NC*32)'(i_cmag);
        dpad = (NC*32)'(i_dmag);
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < NC; i++) begin
                n_pc[j*NC+i] = 64'(cv[32*j +: 32]) * 64'(cpad[32*i +: 32]);
                n_ps[j*NC+i] = 64'(sv[32*j +: 32]) * 64'(dpad[32*i +: 32]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctla  <= i_ctl;
            r_cmaga <= i_cmag;
            r_dmaga <= i_dmag;
            r_mid   <= mid;
            r_pc    <= n_pc;
            r_ps    <= n_ps;
        end
    end

    always_comb begin
        lmag = '0;
        rmag = '0;
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < NC; i++) begin
                lmag = lmag + (SW'(r_pc[j*NC+i]) << (32 * (i + j)));
                rmag = rmag + (SW'(r_ps[j*NC+i]) << (32 * (i + j)));
            end
        end
        lneg = (r_mid > vau_pkg::ANGLE_RIGHT) && (lmag != '0);
        rneg = r_ctla.dneg && (rmag != '0);
        if (lneg != rneg) begin
            ge = !lneg;
        end else if (lneg) begin
            ge = (lmag <= rmag);
        end else begin
            ge = (lmag >= rmag);
        end
        if (r_mid >= vau_pkg::ANGLE_MAX) begin
            hit = (r_cmaga == '0) && r_ctla.dneg && (r_dmaga != '0);
        end else begin
            hit = ge;
        end
        n_ctl = r_ctla;
        if (r_ctla.lo != r_ctla.hi) begin
            if (hit) begin
                n_ctl.lo = r_mid;
            end else begin
                n_ctl.hi = r_mid - AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctlb  <= n_ctl;
            r_cmagb <= r_cmaga;
            r_dmagb <= r_dmaga;
        end
    end

    assign o_valid = r_vb;
    assign o_ctl   = r_ctlb;
    assign o_cmag  = r_cmagb;
    assign o_dmag  = r_dmagb;
endmodule

// ----- rtl/vector_angle_unit_2d_top.sv -----
// Top level of the vector angle unit: front end, search pipeline, output register.
//
// The unit takes two signed 2D vectors a = (first_x, first_y) and
// b = (second_x, second_y) on the input channel and returns the angle between
// them in whole degrees (0 to 180, truncated) with four flags on the output
// channel. A transfer happens when valid is high and stall is low.
//
// The pipeline is 19 register stages deep: two stages form the products and
// the dot and cross magnitudes, eight binary search steps of two stages each
// (table lookup with partial products, then a wide add and compare) find the
// angle, and one output register holds the result. One vector pair can be
// accepted every cycle while the receiver does not stall the output.
//
// The whole pipeline advances together. When the output register holds a
// result that the receiver stalls, every stage holds and o_stall is raised,
// so nothing is lost or repeated; otherwise the unit takes a new transfer
// in every cycle, even while earlier items are still in flight.
// Reset clears all valid bits; no item is in flight afterwards.
module vector_angle_unit_2d_top #(
    parameter int COMPONENT_BITS = vau_pkg::COMPONENT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [COMPONENT_BITS-1:0] i_first_x,
    input  logic signed [COMPONENT_BITS-1:0] i_first_y,
    input  logic signed [COMPONENT_BITS-1:0] i_second_x,
    input  logic signed [COMPONENT_BITS-1:0] i_second_y,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [vau_pkg::ANGLE_W-1:0]      o_angle_degrees,
    output logic                             o_same_direction,
    output logic                             o_opposite_direction,
    output logic                             o_perpendicular,
    output logic                             o_invalid_length
);
    localparam int MAG_W = 2 * COMPONENT_BITS;
    localparam int NS = vau_pkg::SEARCH_STEPS;

    logic          advance;
    logic          s_valid [NS+1];
    vau_pkg::t_ctl s_ctl   [NS+1];
    logic [MAG_W-1:0] s_cmag [NS+1];
    logic [MAG_W-1:0] s_dmag [NS+1];

    logic                        r_valid;
    logic [vau_pkg::ANGLE_W-1:0] r_angle;
    logic                        r_same;
    logic                        r_opp;
    logic                        r_perp;
    logic                        r_inv;

    // Everything moves unless a finished result is waiting on the receiver.
    assign advance = !(r_valid && i_stall);
    assign o_stall = !advance;

    vau_front #(.CB(COMPONENT_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (i_valid),
        .i_ax    (i_first_x),
        .i_ay    (i_first_y),
        .i_bx    (i_second_x),
        .i_by    (i_second_y),
        .o_valid (s_valid[0]),
        .o_ctl   (s_ctl[0]),
        .o_cmag  (s_cmag[0]),
        .o_dmag  (s_dmag[0])
    );

    for (genvar g = 0; g < NS; g++) begin : g_step
        vau_search_step #(.MAG_W(MAG_W)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_valid (s_valid[g]),
            .i_ctl   (s_ctl[g]),
            .i_cmag  (s_cmag[g]),
            .i_dmag  (s_dmag[g]),
            .o_valid (s_valid[g+1]),
            .o_ctl   (s_ctl[g+1]),
            .o_cmag  (s_cmag[g+1]),
            .o_dmag  (s_dmag[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= s_valid[NS];
        end
    end

    // A zero-length vector forces the angle and the direction flags to zero.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_inv   <= s_ctl[NS].inv;
            r_angle <= s_ctl[NS].inv ? '0 : s_ctl[NS].lo;
            r_same  <= !s_ctl[NS].inv && (s_ctl[NS].lo == '0);
            r_opp   <= !s_ctl[NS].inv && s_ctl[NS].opp;
            r_perp  <= !s_ctl[NS].inv && s_ctl[NS].perp;
        end
    end

    assign o_valid              = r_valid;
    assign o_angle_degrees      = r_angle;
    assign o_same_direction     = r_same;
    assign o_opposite_direction = r_opp;
    assign o_perpendicular      = r_perp;
    assign o_invalid_length     = r_inv;
endmodule

// ----- rtl/vau_checker.sv -----
// Port-level checker of the vector angle unit, bound to the top level.
module vau_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_angle_degrees,
    input logic       o_same_direction,
    input logic       o_opposite_direction,
    input logic       o_perpendicular,
    input logic       o_invalid_length
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_same_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_same_direction |-> o_angle_degrees == 8'd0)
        else $error("same direction with nonzero angle");

    a_opp_180: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_opposite_direction |-> o_angle_degrees == 8'd180)
        else $error("opposite direction without 180 degrees");

    a_invalid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid_length |-> o_angle_degrees == 8'd0
            && !o_same_direction && !o_opposite_direction && !o_perpendicular)
        else $error("zero-length result carries angle or flags");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_angle_degrees))
        else $error("stalled result changed");
endmodule

bind vector_angle_unit_2d_top vau_checker u_vau_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_valid              (o_valid),
    .i_stall              (i_stall),
    .o_angle_degrees      (o_angle_degrees),
    .o_same_direction     (o_same_direction),
    .o_opposite_direction (o_opposite_direction),
    .o_perpendicular      (o_perpendicular),
    .o_invalid_length     (o_invalid_length)
);

// ----- bench/vector_angle_unit_2d_top_tb.sv -----
// Self-checking testbench of the vector angle unit with an angle predictor and random stalls.
module vector_angle_unit_2d_top_tb;

    localparam int NB = vau_pkg::COMPONENT_BITS_DEF;
    localparam int AW = vau_pkg::ANGLE_W;
    localparam int N_RANDOM = 1700;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY = 19;

    typedef struct packed {
        logic [AW-1:0] angle;
        logic          same;
        logic          opp;
        logic          perp;
        logic          inv;
    } t_angle_res;

    // One row of the directed part; chk is set where the expected result is typed in.
    typedef struct {
        logic signed [NB-1:0] ax;
        logic signed [NB-1:0] ay;
        logic signed [NB-1:0] bx;
        logic signed [NB-1:0] by;
        bit                   chk;
        t_angle_res           res;
    } t_vec_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [NB-1:0] i_first_x = '0;
    logic signed [NB-1:0] i_first_y = '0;
    logic signed [NB-1:0] i_second_x = '0;
    logic signed [NB-1:0] i_second_y = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [AW-1:0]        o_angle_degrees;
    logic                 o_same_direction;
    logic                 o_opposite_direction;
    logic                 o_perpendicular;
    logic                 o_invalid_length;

    t_angle_res    expected_angles[$];
    vau_pkg::t_q62 cos_deg [0:90];
    vau_pkg::t_q62 sin_deg [0:90];
    int            n_mismatch = 0;
    int            n_results = 0;
    int            n_cycles = 0;
    bit            calm = 1'b0;
    bit            long_hold = 1'b0;

    vector_angle_unit_2d_top DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Q2.62 product, truncated.
    function automatic vau_pkg::t_q62 q62_mul(vau_pkg::t_q62 a, vau_pkg::t_q62 b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[125:62];
    endfunction

    // Sine and cosine of whole degrees from their Taylor series, summed term by term.
    task automatic fill_trig_tables();
        vau_pkg::t_q62 x;
        vau_pkg::t_q62 x2;
        vau_pkg::t_q62 st;
        vau_pkg::t_q62 ct;
        vau_pkg::t_q62 ss;
        vau_pkg::t_q62 cs;
        for (int m = 0; m <= 90; m++) begin
            x = 64'(m) * (64'hC90FDAA22168C234 / 64'd180);
            x2 = q62_mul(x, x);
            st = x; ss = x; ct = 64'h4000000000000000; cs = ct;
            for (int n = 1; n < 40; n++) begin
                st = q62_mul(st, x2) / 64'((2 * n) * (2 * n + 1));
                ct = q62_mul(ct, x2) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) begin
                    ss -= st; cs -= ct;
                end else begin
                    ss += st; cs += ct;
                end
                if (st == 0 && ct == 0) break;
            end
            cos_deg[m] = cs;
            sin_deg[m] = (m == 45) ? cs : ss;
        end
        cos_deg[90] = '0;
        sin_deg[90] = 64'h4000000000000000;
    endtask

    // True when the angle whose |cross| and dot are given is at least k degrees.
    function automatic bit angle_reaches(int k, logic [63:0] cmag, bit dneg,
                                         logic [63:0] dmag);
        int m;
        logic signed [129:0] lhs;
        logic signed [129:0] rhs;
        if (k >= 180) return cmag == 0 && dneg && dmag != 0;
        m = (k > 90) ? 180 - k : k;
        lhs = $signed({2'b0, {64'b0, cos_deg[m]} * {64'b0, cmag}});
        rhs = $signed({2'b0, {64'b0, sin_deg[m]} * {64'b0, dmag}});
        if (k > 90) lhs = -lhs;
        if (dneg) rhs = -rhs;
        return lhs >= rhs;
    endfunction

    function automatic t_angle_res predict_angle(logic signed [NB-1:0] ax,
            logic signed [NB-1:0] ay, logic signed [NB-1:0] bx, logic signed [NB-1:0] by);
        t_angle_res r;
        logic signed [64:0] dot;
        logic signed [64:0] crs;
        logic [63:0] dmag;
        logic [63:0] cmag;
        int lo;
        int hi;
        int mid;
        r = '0;
        if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
            r.inv = 1'b1;
            return r;
        end
        dot = 65'(ax) * 65'(bx) + 65'(ay) * 65'(by);
        crs = 65'(ax) * 65'(by) - 65'(ay) * 65'(bx);
        dmag = (dot < 0) ? 64'(-dot) : 64'(dot);
        cmag = (crs < 0) ? 64'(-crs) : 64'(crs);
        lo = 0; hi = 180;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (angle_reaches(mid, cmag, dot < 0, dmag)) lo = mid;
            else hi = mid - 1;
        end
        r.angle = AW'(lo);
        r.same = (lo == 0);
        r.opp = (cmag == 0 && dot < 0);
        r.perp = (dmag == 0);
        return r;
    endfunction

    // Offers one vector pair and holds it until the unit takes the transfer.
    task automatic send_pair(t_vec_row row);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        expected_angles.push_back(row.chk ? row.res :
                                  predict_angle(row.ax, row.ay, row.bx, row.by));
        i_valid <= 1'b1;
        i_first_x <= row.ax;
        i_first_y <= row.ay;
        i_second_x <= row.bx;
        i_second_y <= row.by;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic signed [NB-1:0] pick_component();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1: return NB'($signed($urandom_range(0, 6)) - 3);
            2: return NB'($signed($urandom_range(0, 200)) - 100);
            default: return NB'($urandom);
        endcase
    endfunction

    // The receiver stalls in random bursts, once for a long stretch that fills the pipeline.
    always @(posedge i_clk) begin
        if (long_hold) begin
            i_stall <= 1'b1;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else if (i_stall) begin
            i_stall <= ($urandom_range(0, 3) != 0);
        end else begin
            i_stall <= ($urandom_range(0, 9) == 0);
        end
    end

    initial begin
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        long_hold = 1'b1;
        repeat (60) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_angle_res got;
        t_angle_res exp_r;
        n_cycles <= n_cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_angle_degrees, o_same_direction, o_opposite_direction,
                   o_perpendicular, o_invalid_length};
            n_results <= n_results + 1;
            if (expected_angles.size() == 0) begin
                n_mismatch <= n_mismatch + 1;
                if (n_mismatch < 10) $display("unexpected result %p", got);
            end else begin
                exp_r = expected_angles.pop_front();
                if (got !== exp_r) begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10)
                        $display({"mismatch: expected angle %0d s%b o%b p%b i%b,",
                                  " got %0d s%b o%b p%b i%b"},
                                 exp_r.angle, exp_r.same, exp_r.opp, exp_r.perp, exp_r.inv,
                                 got.angle, got.same, got.opp, got.perp, got.inv);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (n_cycles > CYCLE_LIMIT) begin
            $display("[vector_angle_unit_2d_top] ERROR");
            $finish;
        end
    end

    t_vec_row directed [] = '{
        '{16'sd0, 16'sd0, 16'sd5, 16'sd1, 1'b1, '{8'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{16'sd3, 16'sd4, 16'sd0, 16'sd0, 1'b1, '{8'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{16'sd1, 16'sd0, 16'sd7, 16'sd0, 1'b1, '{8'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{16'sd1, 16'sd0, -16'sd1, 16'sd0, 1'b1, '{8'd180, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{16'sd1, 16'sd0, 16'sd0, 16'sd9, 1'b1, '{8'd90, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{16'sd0, -16'sd3, 16'sd2, 16'sd0, 1'b1, '{8'd90, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{16'sd1, 16'sd0, 16'sd1, 16'sd1, 1'b1, '{8'd45, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{16'sd1, 16'sd0, -16'sd1, 16'sd1, 1'b1, '{8'd135, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b0, '0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
        '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b0, '0},
        '{16'sd32767, 16'sd0, 16'sd32767, 16'sd1, 1'b0, '0},
        '{16'sd32767, 16'sd0, -16'sd32767, 16'sd1, 1'b0, '0},
        '{16'sd2, 16'sd1, -16'sd1, 16'sd2, 1'b0, '0},
        '{16'sd1, 16'sd0, 16'sd866, 16'sd500, 1'b0, '0},
        '{-16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 1'b0, '0},
        '{16'sd100, 16'sd1, 16'sd100, 16'sd2, 1'b0, '0}
    };

    initial begin
        t_vec_row row;
        fill_trig_tables();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) send_pair(directed[i]);
        for (int n = 0; n < N_RANDOM; n++) begin
            // The last stretch of the run goes without any idle cycles.
            if (n == N_RANDOM - 150) calm = 1'b1;
            row.ax = pick_component();
            row.ay = pick_component();
            row.bx = pick_component();
            row.by = pick_component();
            // Now and then the second vector is a copy, a negated copy or a copy of the first turned by 90 degrees.
            case ($urandom_range(0, 9))
                0: begin row.bx = row.ax; row.by = row.ay; end
                1: begin row.bx = -row.ax; row.by = -row.ay; end
                2: begin row.bx = -row.ay; row.by = row.ax; end
                default: ;
            endcase
            row.chk = 1'b0;
            send_pair(row);
        end
        i_valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("Sent %0d vector pairs (directed and random, with stalls and a long hold).",
                 directed.size() + N_RANDOM);
        $display("Checked %0d results, %0d mismatches.", n_results, n_mismatch);
        if (n_mismatch == 0) begin
            $display("[vector_angle_unit_2d_top] OK");
        end else begin
            $display("[vector_angle_unit_2d_top] ERROR");
        end
        $finish;
    end

endmodule
